// File: rtl/lrtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrtf_pkg;

  // Slot count and derived widths
  localparam int MaxProcs = 16;
  localparam int SlotW    = 4;
  localparam int IdxW     = $clog2(MaxProcs + 1);

  // Field widths
  localparam int ValW   = 16;
  localparam int TimeW  = 21;
  localparam int CountW = 5;

  // Operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  // Choice code for an idle tick
  localparam logic [IdxW-1:0] IdleCode = IdxW'(MaxProcs);

  typedef struct packed {
    logic            op;
    logic [SlotW-1:0] slot;
    logic [ValW-1:0]  arrival_time;
    logic [ValW-1:0]  burst_time;
  } in_t;

  typedef struct packed {
    logic [TimeW-1:0] tick_time;
    logic [SlotW-1:0] running_slot;
    logic             idle;
    logic             switched;
    logic             finished;
    logic [TimeW-1:0] completion_time;
    logic [TimeW-1:0] turnaround_time;
    logic [TimeW-1:0] waiting_time;
    logic [TimeW-1:0] response_time;
    logic             all_done;
  } out_t;

  // Remaining work and arrival of one slot, as seen by the compare unit
  typedef struct packed {
    logic [ValW-1:0] rem;
    logic [ValW-1:0] arr;
  } ent_t;

endpackage

`default_nettype wire

// File: rtl/lrtf_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module lrtf_pick (
  input  lrtf_pkg::ent_t                   cand_i,
  input  lrtf_pkg::ent_t                   best_i,
  input  logic                             found_i,
  input  logic [lrtf_pkg::TimeW-1:0]       now_i,
  output logic                             take_o
);
  import lrtf_pkg::*;

  logic eligible;
  logic better;

  // Eligible: work left and already arrived
  assign eligible = (cand_i.rem != '0) && ({{(TimeW-ValW){1'b0}}, cand_i.arr} <= now_i);

  // Longer remaining wins, then earlier arrival; scan order settles the rest
  assign better = (cand_i.rem > best_i.rem) ||
                  ((cand_i.rem == best_i.rem) && (cand_i.arr < best_i.arr));

  assign take_o = eligible && (!found_i || better);

endmodule

`default_nettype wire

// File: rtl/longest_remaining_time_first_sched_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Preemptive longest-remaining-time-first scheduler. A load word (op 0) writes
// one slot's arrival and burst, resets its remaining count and clears its
// started mark; it produces no result. A tick word (op 1) scans slots
// 0 .. min(process_count, 16)-1 through one read port of the slot stores and
// one shared compare unit, one slot per cycle, then updates the chosen slot,
// if there is one, and emits one result word. The next word can be taken in
// the cycle after the result loads; a result that is still unread holds the
// tick until the output register is free. Input stall is high while a tick
// is in progress; a result waits in an output register, so a new word can be
// taken while it is unread. process_count is written through cfg_we_i /
// cfg_data_i while the block is idle; the user is bound to this, as the block
// itself does not enforce it. Slots that are scanned must have been loaded
// since reset.

module longest_remaining_time_first_sched_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrtf_pkg::CountW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lrtf_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lrtf_pkg::out_t                out_data_o
);
  import lrtf_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StFetch,
    StUpdate,
    StStats,
    StOut
  } st_e;

  // Slot stores: one write port, one registered read port each
  logic [ValW-1:0]  rem_mem [MaxProcs];
  logic [ValW-1:0]  arr_mem [MaxProcs];
  logic [ValW-1:0]  bst_mem [MaxProcs];
  logic [TimeW-1:0] rsp_mem [MaxProcs];

  logic [ValW-1:0]  rem_rd_q, arr_rd_q, bst_rd_q;
  logic [TimeW-1:0] rsp_rd_q;

  st_e              st_q;
  logic [CountW-1:0] count_q;
  logic [TimeW-1:0] time_q;
  logic [IdxW-1:0]  prev_q;
  logic [CountW-1:0] done_q;
  logic [MaxProcs-1:0] started_q;

  logic [IdxW-1:0]  idx_q;
  logic             pend_q;
  logic [SlotW-1:0] pidx_q;
  logic             found_q;
  logic [SlotW-1:0] best_q;
  ent_t             best_ent_q;

  out_t             res_q;
  out_t             out_d;
  out_t             out_q;
  logic             out_valid_q;

  logic             in_acc;
  logic [SlotW-1:0] raddr;
  logic [IdxW-1:0]  scan_w;
  logic             take;
  ent_t             cand;
  logic [ValW-1:0]  rem_new;
  logic [TimeW-1:0] ct;
  logic [TimeW-1:0] first_rsp;
  logic [IdxW-1:0]  choice;
  logic             out_free;

  logic             rem_we;
  logic [SlotW-1:0] rem_wa;
  logic [ValW-1:0]  rem_wd;
  logic             ld_we;
  logic             rsp_we;

  assign in_stall_o  = (st_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Clamp the scan length to the slot count
  assign scan_w = ({1'b0, count_q} > (CountW + 1)'(MaxProcs))
                  ? IdxW'(MaxProcs) : IdxW'(count_q);

  assign cand.rem = rem_rd_q;
  assign cand.arr = arr_rd_q;

  lrtf_pick u_pick (
    .cand_i  (cand),
    .best_i  (best_ent_q),
    .found_i (found_q),
    .now_i   (time_q),
    .take_o  (take)
  );

  // Read address: scan index while scanning, chosen slot afterwards
  always_comb begin
    unique case (st_q)
      StScan:  raddr = idx_q[SlotW-1:0];
      default: raddr = best_q;
    endcase
  end

  assign rem_new   = rem_rd_q - ValW'(1);
  assign ct        = time_q + TimeW'(1);
  assign first_rsp = started_q[best_q] ? rsp_rd_q
                                       : time_q - {{(TimeW-ValW){1'b0}}, arr_rd_q};
  assign choice    = res_q.idle ? IdleCode : IdxW'(best_q);

  // Result word as it leaves: switch and all-done flags are settled last
  always_comb begin
    out_d          = res_q;
    out_d.switched = (choice != prev_q);
    out_d.all_done = (done_q >= count_q);
  end

  // Store write ports
  always_comb begin
    ld_we  = in_acc && (in_data_i.op == OpLoad);
    rsp_we = (st_q == StUpdate) && !started_q[best_q];
    rem_we = ld_we || (st_q == StUpdate);
    rem_wa = ld_we ? in_data_i.slot : best_q;
    rem_wd = ld_we ? in_data_i.burst_time : rem_new;
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (ld_we) begin
      arr_mem[in_data_i.slot] <= in_data_i.arrival_time;
      bst_mem[in_data_i.slot] <= in_data_i.burst_time;
    end
    if (rsp_we) begin
      rsp_mem[best_q] <= first_rsp;
    end
    rem_rd_q <= rem_mem[raddr];
    arr_rd_q <= arr_mem[raddr];
    bst_rd_q <= bst_mem[raddr];
    rsp_rd_q <= rsp_mem[raddr];
  end

  // Sequencer, scheduler state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      count_q     <= CountW'(1);
      time_q      <= '0;
      prev_q      <= IdleCode;
      done_q      <= '0;
      started_q   <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_ent_q  <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      // Drop a taken word unless a new one loads in its place
      if (out_valid_q && !out_stall_i && (st_q != StOut)) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        StIdle: begin
          if (in_acc) begin
            if (in_data_i.op == OpLoad) begin
              started_q[in_data_i.slot] <= 1'b0;
            end else begin
              // Start a tick: the result is already clear, reset the running best
              idx_q           <= '0;
              pend_q          <= 1'b0;
              found_q         <= 1'b0;
              best_q          <= '0;
              res_q.tick_time <= time_q;
              st_q            <= StScan;
            end
          end
        end

        StScan: begin
          if (pend_q && take) begin
            found_q    <= 1'b1;
            best_q     <= pidx_q;
            best_ent_q <= cand;
          end
          if (idx_q < scan_w) begin
            pend_q <= 1'b1;
            pidx_q <= idx_q[SlotW-1:0];
            idx_q  <= idx_q + IdxW'(1);
          end else begin
            pend_q <= 1'b0;
          end
          if ((idx_q >= scan_w) && !pend_q) begin
            res_q.idle         <= !found_q;
            res_q.running_slot <= found_q ? best_q : '0;
            st_q               <= found_q ? StFetch : StOut;
          end
        end

        StFetch: begin
          // Read of the chosen slot is in flight
          st_q <= StUpdate;
        end

        StUpdate: begin
          started_q[best_q] <= 1'b1;
          if (rem_new == '0) begin
            res_q.finished        <= 1'b1;
            res_q.completion_time <= ct;
            res_q.turnaround_time <= ct - {{(TimeW-ValW){1'b0}}, arr_rd_q};
            res_q.response_time   <= first_rsp;
            if (done_q != '1) begin
              done_q <= done_q + CountW'(1);
            end
            st_q <= StStats;
          end else begin
            st_q <= StOut;
          end
        end

        StStats: begin
          res_q.waiting_time <= res_q.turnaround_time - {{(TimeW-ValW){1'b0}}, bst_rd_q};
          st_q               <= StOut;
        end

        StOut: begin
          // Hold until the output register is free, then advance time
          if (out_free) begin
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            res_q       <= '0;
            prev_q      <= choice;
            time_q      <= ct;
            st_q        <= StIdle;
          end
        end

        default: begin
          st_q <= StIdle;
        end
      endcase
    end
  end

  // A finished process is never reported on an idle tick
  a_fin_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.finished |-> !out_data_o.idle)
    else $error("finish reported on an idle tick");

  // Idle results carry no slot and no statistics
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.idle |->
      (out_data_o.running_slot == '0) && (out_data_o.completion_time == '0))
    else $error("idle result carries slot or statistics");

  // Completion count never moves backward
  a_done_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (done_q >= $past(done_q)))
    else $error("completion count decreased");

  // Time only advances when a result is loaded
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StOut) |=> (time_q == $past(time_q)))
    else $error("time advanced outside result load");

endmodule

`default_nettype wire
